// ===== rtl/ptq_pkg.sv =====
// Shared constants, codes and types for the periodic timer queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ptq_pkg;
    localparam int CAPACITY    = 16;
    localparam int SLOT_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W      = 32;
    localparam int DELAY_W     = 24;
    localparam int TAG_W       = 8;
    localparam int QDEPTH      = 2;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] ST_FIRED  = 2'd0;
    localparam logic [1:0] ST_ADD_OK = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_NONE   = 2'd3;

    typedef struct packed {
        logic               command;
        logic [DELAY_W-1:0] delay;
        logic [DELAY_W-1:0] reload;
        logic [TAG_W-1:0]   tag;
    } t_cmd;
endpackage
`default_nettype wire

// ===== rtl/ptq_front.sv =====
// Front end: accepts input transactions into a two-entry command queue.
// Depends on ptq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptq_front import ptq_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_command,
    input  wire logic [DELAY_W-1:0] i_delay,
    input  wire logic [DELAY_W-1:0] i_reload,
    input  wire logic [TAG_W-1:0]   i_timer_tag,
    output logic                    o_cmd_valid,
    output t_cmd                    o_cmd,
    input  wire logic               i_cmd_pop
);
    t_cmd       r_mem [QDEPTH];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready     = (r_cnt != 2'(QDEPTH));
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= '{command: i_command, delay: i_delay,
                             reload: i_reload, tag: i_timer_tag};
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/ptq_engine.sv =====
// Back end: timer slots, time count, due-timer scan and output register.
// Depends on ptq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptq_engine import ptq_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    input  wire t_cmd        i_cmd,
    output logic             o_cmd_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [TAG_W-1:0] o_fired_tag,
    output logic             o_last
);
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;

    logic [1:0]        r_state;
    logic [TIME_W-1:0] r_time;
    logic              r_valid [CAPACITY];
    logic [TIME_W-1:0] r_dl    [CAPACITY];
    logic [DELAY_W-1:0] r_rl   [CAPACITY];
    logic [TAG_W-1:0]  r_tag   [CAPACITY];
    logic [SLOT_W-1:0] r_idx;
    logic [SLOT_W-1:0] r_best;
    logic [TIME_W-1:0] r_best_age;
    logic              r_found;
    logic [CNT_W-1:0]  r_count;
    logic              r_pend;
    logic [TAG_W-1:0]  r_pend_tag;
    logic              r_ovalid;
    logic [1:0]        r_ostatus;
    logic [TAG_W-1:0]  r_otag;
    logic              r_olast;

    logic              out_free;
    logic [TIME_W-1:0] age;
    logic              due;
    logic              free_any;
    logic [SLOT_W-1:0] free_idx;
    logic              fire;

    assign out_free    = !r_ovalid || i_ready;
    assign o_valid     = r_ovalid;
    assign o_status    = r_ostatus;
    assign o_fired_tag = r_otag;
    assign o_last      = r_olast;
    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid && out_free;
    assign age         = r_time - r_dl[r_idx];
    assign due         = r_valid[r_idx] && !age[TIME_W-1];
    assign fire        = r_found && (r_count < CNT_W'(MAX_RESULTS));

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_time   <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < CAPACITY; i++) r_valid[i] <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        if (i_cmd.command == CMD_ADD) begin
                            r_ovalid  <= 1'b1;
                            r_otag    <= '0;
                            r_olast   <= 1'b1;
                            r_ostatus <= free_any ? ST_ADD_OK : ST_FULL;
                            if (free_any) begin
                                r_valid[free_idx] <= 1'b1;
                                r_dl[free_idx]  <= r_time + TIME_W'(i_cmd.delay);
                                r_rl[free_idx]  <= i_cmd.reload;
                                r_tag[free_idx] <= i_cmd.tag;
                            end
                        end else begin
                            r_time  <= r_time + 1'b1;
                            r_count <= '0;
                            r_pend  <= 1'b0;
                            r_idx   <= '0;
                            r_found <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (due && (!r_found || age > r_best_age)) begin
                        r_found    <= 1'b1;
                        r_best     <= r_idx;
                        r_best_age <= age;
                    end
                    if (r_idx == SLOT_W'(CAPACITY - 1)) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DECIDE: begin
                    if (fire) begin
                        if (!r_pend || out_free) begin
                            if (r_pend) begin
                                r_ovalid  <= 1'b1;
                                r_ostatus <= ST_FIRED;
                                r_otag    <= r_pend_tag;
                                r_olast   <= 1'b0;
                            end
                            r_pend     <= 1'b1;
                            r_pend_tag <= r_tag[r_best];
                            r_count    <= r_count + 1'b1;
                            if (r_rl[r_best] != '0) begin
                                r_dl[r_best] <= r_time + TIME_W'(r_rl[r_best]);
                            end else begin
                                r_valid[r_best] <= 1'b0;
                            end
                            r_idx   <= '0;
                            r_found <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end else if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_olast   <= 1'b1;
                        r_ostatus <= r_pend ? ST_FIRED : ST_NONE;
                        r_otag    <= r_pend ? r_pend_tag : '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/periodic_timer_queue_top.sv =====
// Top level of the periodic timer queue: command queue front end and
// timer engine. Depends on ptq_pkg, ptq_front and ptq_engine.
//
// Input channel (i_valid/o_ready) carries one command per transaction:
// add a timer (delay, reload, tag) or tick time forward by one unit.
// Output channel (o_valid/i_ready) carries results: status, fired tag and
// a last flag on the final result of each command.
// An add produces one result. A tick finds each fired timer by a scan
// of all CAPACITY slots, one slot per cycle, through a single age
// comparator.
// A two-entry command queue keeps accepting while the engine is busy.
// Reset clears the time count and all slot valid flags; the queue and
// the output register come up empty. When the receiver stalls, the held
// result stays on the outputs and the engine waits before the next one.
`timescale 1ns / 1ps
`default_nettype none
module periodic_timer_queue_top import ptq_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_command,
    input  wire logic [DELAY_W-1:0] i_delay,
    input  wire logic [DELAY_W-1:0] i_reload,
    input  wire logic [TAG_W-1:0]   i_timer_tag,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [1:0]              o_status,
    output logic [TAG_W-1:0]        o_fired_tag,
    output logic                    o_last
);
    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    ptq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_delay     (i_delay),
        .i_reload    (i_reload),
        .i_timer_tag (i_timer_tag),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    ptq_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_fired_tag (o_fired_tag),
        .o_last      (o_last)
    );
endmodule
`default_nettype wire

// ===== rtl/ptq_checker.sv =====
// Port-level checks for the periodic timer queue, bound to the top level.
// Depends on ptq_pkg and periodic_timer_queue_top.
`timescale 1ns / 1ps
`default_nettype none
module ptq_checker import ptq_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_valid,
    input wire logic             i_ready,
    input wire logic [1:0]       o_status,
    input wire logic [TAG_W-1:0] o_fired_tag,
    input wire logic             o_last
);
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("output valid after reset");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_FIRED |-> o_last)
        else $error("non-fire result without last");

    a_zero_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_FIRED |-> o_fired_tag == '0)
        else $error("tag set on non-fire result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)
            && $stable(o_fired_tag) && $stable(o_last))
        else $error("stalled result changed");
endmodule

bind periodic_timer_queue_top ptq_checker u_ptq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_status    (o_status),
    .o_fired_tag (o_fired_tag),
    .o_last      (o_last)
);
`default_nettype wire

// ===== verif/periodic_timer_queue_top_test.sv =====
// Testbench for the periodic timer queue: directed and random add and tick
// transactions, checked against a built-in predictor. Depends on ptq_pkg and
// periodic_timer_queue_top.
`timescale 1ns / 1ps
module periodic_timer_queue_top_test;
    import ptq_pkg::*;

    typedef struct {
        logic [1:0]       status;
        logic [TAG_W-1:0] tag;
        logic             last;
    } t_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_command = CMD_ADD;
    logic [DELAY_W-1:0] i_delay = '0;
    logic [DELAY_W-1:0] i_reload = '0;
    logic [TAG_W-1:0]   i_timer_tag = '0;
    logic               i_ready = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic [1:0]         o_status;
    logic [TAG_W-1:0]   o_fired_tag;
    logic               o_last;

    periodic_timer_queue_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_command(i_command), .i_delay(i_delay), .i_reload(i_reload),
        .i_timer_tag(i_timer_tag), .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_fired_tag(o_fired_tag), .o_last(o_last)
    );

    logic [TIME_W-1:0]  now_count;
    logic               armed [CAPACITY];
    logic [TIME_W-1:0]  due_at [CAPACITY];
    logic [DELAY_W-1:0] period [CAPACITY];
    logic [TAG_W-1:0]   owner_tag [CAPACITY];
    t_result            pending_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;
    int fired_seen = 0;
    int rejects_seen = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void push_result(logic [1:0] st, logic [TAG_W-1:0] tg, logic lst);
        t_result r;
        r.status = st;
        r.tag = tg;
        r.last = lst;
        pending_results.push_back(r);
    endfunction

    task automatic predict_timers(logic cmd, logic [DELAY_W-1:0] dly,
                                  logic [DELAY_W-1:0] rld, logic [TAG_W-1:0] tg);
        int best;
        int count;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] best_age;
        if (cmd == CMD_ADD) begin
            for (int s = 0; s < CAPACITY; s++) begin
                if (!armed[s]) begin
                    armed[s] = 1'b1;
                    due_at[s] = now_count + TIME_W'(dly);
                    period[s] = rld;
                    owner_tag[s] = tg;
                    push_result(ST_ADD_OK, '0, 1'b1);
                    return;
                end
            end
            push_result(ST_FULL, '0, 1'b1);
            return;
        end
        now_count = now_count + 1;
        count = 0;
        while (count < MAX_RESULTS) begin
            best = -1;
            best_age = '0;
            for (int s = 0; s < CAPACITY; s++) begin
                age = now_count - due_at[s];
                if (armed[s] && !age[TIME_W-1] && (best < 0 || age > best_age)) begin
                    best = s;
                    best_age = age;
                end
            end
            if (best < 0) break;
            push_result(ST_FIRED, owner_tag[best], 1'b0);
            count++;
            if (period[best] != 0) due_at[best] = now_count + TIME_W'(period[best]);
            else armed[best] = 1'b0;
        end
        if (count == 0) push_result(ST_NONE, '0, 1'b1);
        else pending_results[pending_results.size() - 1].last = 1'b1;
    endtask

    task automatic send_command(logic cmd, logic [DELAY_W-1:0] dly,
                                logic [DELAY_W-1:0] rld, logic [TAG_W-1:0] tg);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_command = cmd;
        i_delay = dly;
        i_reload = rld;
        i_timer_tag = tg;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_timers(cmd, dly, rld, tg);
        items_sent++;
    endtask

    task automatic release_bus();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_drained();
        release_bus();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (o_status == ST_FIRED) fired_seen++;
            if (o_status == ST_FULL) rejects_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status %0d tag %0d last %0b",
                             o_status, o_fired_tag, o_last);
            end else begin
                want = pending_results.pop_front();
                if (want.status !== o_status || want.tag !== o_fired_tag
                        || want.last !== o_last) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                                 want.status, want.tag, want.last,
                                 o_status, o_fired_tag, o_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_directed();
        send_command(CMD_TICK, '1, '1, '1);
        send_command(CMD_ADD, '0, '0, 8'h00);
        send_command(CMD_ADD, '1, '1, 8'hFF);
        send_command(CMD_ADD, '0, 24'd1, 8'hA5);
        send_command(CMD_TICK, '0, '0, '0);
        send_command(CMD_TICK, 24'h5A5A5A, 24'hA5A5A5, 8'h5A);
        for (int k = 0; k < 14; k++) send_command(CMD_ADD, 24'd1, '0, TAG_W'(k + 1));
        send_command(CMD_ADD, 24'd3, 24'd2, 8'h77);
        send_command(CMD_TICK, '1, '0, 8'hFF);
        wait_drained();
        send_command(CMD_TICK, '0, '0, '0);
    endtask

    task automatic test_random(int count, int s_pct, int r_pct);
        logic [DELAY_W-1:0] dly;
        logic [DELAY_W-1:0] rld;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 45) begin
                send_command(CMD_TICK, DELAY_W'($urandom), DELAY_W'($urandom),
                             TAG_W'($urandom));
            end else begin
                dly = ($urandom_range(99) < 3) ? DELAY_W'($urandom)
                                                : DELAY_W'($urandom_range(0, 12));
                case ($urandom_range(19))
                    0: rld = DELAY_W'($urandom);
                    1, 2, 3, 4, 5, 6, 7: rld = DELAY_W'($urandom_range(1, 15));
                    default: rld = '0;
                endcase
                send_command(CMD_ADD, dly, rld, TAG_W'($urandom));
            end
            if (n == count / 2) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        now_count = '0;
        for (int s = 0; s < CAPACITY; s++) begin
            armed[s] = 1'b0;
            due_at[s] = '0;
            period[s] = '0;
            owner_tag[s] = '0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(95, 17, 75);
        test_random(95, 75, 17);
        test_random(95, 0, 0);
        release_bus();
        repeat (40) @(posedge i_clk);
        $display("Covered %0d transactions in: %0d timers fired, %0d adds rejected as full.",
                 items_sent, fired_seen, rejects_seen);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
